/* rtl/jrqs_pkg.sv */
// Shared types, register indexes and key selection for the job ready-queue scheduler.
// This package has no dependencies. The scheduler top level uses it.
package jrqs_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_POLICY_MODE    = 2'd0;
  localparam logic [1:0] REG_PREEMPT_ENABLE = 2'd1;
  localparam logic [1:0] REG_QUANTUM_LENGTH = 2'd2;

  // Policy modes.
  localparam logic [1:0] MODE_FCFS     = 2'd0;
  localparam logic [1:0] MODE_SJF      = 2'd1;
  localparam logic [1:0] MODE_PRIORITY = 2'd2;
  localparam logic [1:0] MODE_RR       = 2'd3;

  // Input function codes.
  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  // One queued or running job.
  typedef struct packed {
    logic [7:0]  job;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [7:0]  priority_val;
    logic [15:0] started;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic        accepted;
    logic [4:0]  queue_position;
    logic [7:0]  running_job;
    logic        cpu_idle;
    logic [15:0] time_now;
    logic        finished_valid;
    logic [7:0]  finished_job;
    logic [15:0] waiting_ticks;
    logic [15:0] turnaround_ticks;
    logic [15:0] response_ticks;
    logic        all_done;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SHUP_RD, S_SHUP_WR, S_INS_WR,
    S_HEAD_RD, S_HEAD_GET, S_SHDN_RD, S_SHDN_WR, S_TICK, S_PRE_RD, S_PRE_CMP, S_OUT
  } state_t;

  // What follows once the queue head has been taken onto the CPU.
  typedef enum logic [2:0] {
    CTX_ENQ, CTX_PRE_TICK, CTX_AFTER_DONE, CTX_RR_SWAP, CTX_PREEMPT
  } ctx_t;

  // Sort key of a job under the given policy.
  function automatic logic [15:0] key_of(input logic [1:0] mode, input entry_t e);
    logic [15:0] k;
    if (mode == MODE_SJF) k = e.remaining;
    else if (mode == MODE_PRIORITY) k = {8'd0, e.priority_val};
    else k = e.arrival;
    return k;
  endfunction

  // Difference that reads 0 where it would be negative.
  function automatic logic [15:0] diff_sat(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : 16'd0;
  endfunction

endpackage

/* rtl/job_ready_queue_scheduler.sv */
// Top level of the job ready-queue scheduler: sequencer, queue memory and running job.
// Depends on jrqs_pkg for the entry and result types, codes and key selection.
//
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_ready   | func, job, times, priority, pending flag
// out_    | output    | out_valid / out_ready | one result item per input item
// cfg_    | input     | cfg_valid / cfg_ready | register index and write data
//
// Items are taken one at a time. All queue traffic goes through one write port and one
// registered read port, one slot moved or compared at a time. Reset is synchronous and
// clears control state and configuration. The result waits in the output register while
// out_ready is low; the next item is taken only after it has been loaded there.
module job_ready_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = jrqs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_job_id,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_length,
  input  logic [7:0]  in_job_priority,
  input  logic        in_more_pending,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [4:0]  out_queue_position,
  output logic [7:0]  out_running_job,
  output logic        out_cpu_idle,
  output logic [15:0] out_time_now,
  output logic        out_finished_valid,
  output logic [7:0]  out_finished_job,
  output logic [15:0] out_waiting_ticks,
  output logic [15:0] out_turnaround_ticks,
  output logic [15:0] out_response_ticks,
  output logic        out_all_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  jrqs_pkg::state_t  state_r, state_nxt;
  jrqs_pkg::ctx_t    ctx_r, ctx_nxt;
  jrqs_pkg::entry_t  cur_r, cur_nxt;
  jrqs_pkg::entry_t  nw_r, nw_nxt;
  jrqs_pkg::entry_t  rd_data_r;
  jrqs_pkg::result_t res_r, res_nxt;
  jrqs_pkg::result_t out_r, out_nxt;
  jrqs_pkg::entry_t  mem [QUEUE_DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [15:0]   clk_ticks_r, clk_ticks_nxt;
  logic [15:0]   slice_r, slice_nxt;
  logic [15:0]   idle_r, idle_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    mode_r;
  logic          preempt_r;
  logic [15:0]   quantum_r;

  logic [CW-1:0]    rd_addr;
  logic             we;
  logic [CW-1:0]    wa;
  jrqs_pkg::entry_t wd;

  // Tick arithmetic on the running job.
  logic [15:0]      tk_clk, tk_rem, tk_slice, tk_turn;
  logic             tk_expired;
  jrqs_pkg::entry_t head_job;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jrqs_pkg::MODE_FCFS;
      preempt_r <= 1'b0;
      quantum_r <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jrqs_pkg::REG_POLICY_MODE:    mode_r <= cfg_data[1:0];
        jrqs_pkg::REG_PREEMPT_ENABLE: preempt_r <= cfg_data[0];
        jrqs_pkg::REG_QUANTUM_LENGTH: quantum_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Queue memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[wa[AW-1:0]] <= wd;
    rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jrqs_pkg::S_IDLE;
      ctx_r       <= jrqs_pkg::CTX_ENQ;
      count_r     <= '0;
      cur_r       <= '0;
      clk_ticks_r <= 16'd0;
      slice_r     <= 16'd0;
      idle_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      clk_ticks_r <= clk_ticks_nxt;
      slice_r     <= slice_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    nw_r  <= nw_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
  end

  // Tick arithmetic and the head taken onto the CPU.
  always_comb begin
    tk_clk   = (clk_ticks_r < jrqs_pkg::TIME_MAX) ? clk_ticks_r + 16'd1 : clk_ticks_r;
    tk_rem   = (cur_r.remaining != 16'd0) ? cur_r.remaining - 16'd1 : 16'd0;
    tk_slice = (slice_r != 16'd0) ? slice_r - 16'd1 : 16'd0;
    tk_expired = (slice_r == 16'd1);
    tk_turn  = jrqs_pkg::diff_sat(tk_clk, cur_r.arrival);
    head_job = rd_data_r;
    if (rd_data_r.remaining == rd_data_r.burst) head_job.started = clk_ticks_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    ctx_nxt       = ctx_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    nw_nxt        = nw_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    clk_ticks_nxt = clk_ticks_r;
    slice_nxt     = slice_r;
    idle_nxt      = idle_r;
    out_valid_nxt = out_valid_r;
    rd_addr       = idx_r;
    we            = 1'b0;
    wa            = pos_r;
    wd            = nw_r;
    in_ready      = (state_r == jrqs_pkg::S_IDLE);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      jrqs_pkg::S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          nw_nxt.job          = in_job_id;
          nw_nxt.arrival      = in_arrival_time;
          nw_nxt.remaining    = in_burst_length;
          nw_nxt.burst        = in_burst_length;
          nw_nxt.priority_val = in_job_priority;
          nw_nxt.started      = 16'd0;
          idx_nxt = '0;
          pos_nxt = '0;
          if (in_func == jrqs_pkg::FUNC_ENQUEUE) begin
            ctx_nxt = jrqs_pkg::CTX_ENQ;
            if (in_job_id == 8'd0 || in_arrival_time > clk_ticks_r ||
                count_r == CW'(QUEUE_DEPTH)) begin
              state_nxt = jrqs_pkg::S_OUT;
            end else if (count_r == '0) begin
              state_nxt = jrqs_pkg::S_INS_WR;
            end else begin
              state_nxt = jrqs_pkg::S_SCAN_RD;
            end
          end else begin
            ctx_nxt = jrqs_pkg::CTX_PRE_TICK;
            if (cur_r.job == 8'd0 && count_r != '0) state_nxt = jrqs_pkg::S_HEAD_RD;
            else state_nxt = jrqs_pkg::S_TICK;
            res_nxt.all_done = !in_more_pending;
          end
        end
      end

      // Find the first slot whose key is strictly larger.
      jrqs_pkg::S_SCAN_RD: begin
        rd_addr   = idx_r;
        state_nxt = jrqs_pkg::S_SCAN_CMP;
      end
      jrqs_pkg::S_SCAN_CMP: begin
        if (jrqs_pkg::key_of(mode_r, nw_r) < jrqs_pkg::key_of(mode_r, rd_data_r)) begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r;
          state_nxt = jrqs_pkg::S_SHUP_RD;
        end else if (idx_r + CW'(1) == count_r) begin
          pos_nxt   = count_r;
          state_nxt = jrqs_pkg::S_INS_WR;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = jrqs_pkg::S_SCAN_RD;
        end
      end

      // Open a gap at the insertion point, moving slots up from the tail.
      jrqs_pkg::S_SHUP_RD: begin
        rd_addr   = idx_r - CW'(1);
        state_nxt = jrqs_pkg::S_SHUP_WR;
      end
      jrqs_pkg::S_SHUP_WR: begin
        we      = 1'b1;
        wa      = idx_r;
        wd      = rd_data_r;
        idx_nxt = idx_r - CW'(1);
        if (idx_r - CW'(1) == pos_r) state_nxt = jrqs_pkg::S_INS_WR;
        else state_nxt = jrqs_pkg::S_SHUP_RD;
      end

      jrqs_pkg::S_INS_WR: begin
        we        = 1'b1;
        wa        = pos_r;
        wd        = nw_r;
        count_nxt = count_r + CW'(1);
        if (ctx_r == jrqs_pkg::CTX_ENQ) begin
          res_nxt.accepted       = 1'b1;
          res_nxt.queue_position = 5'(pos_r);
        end
        state_nxt = jrqs_pkg::S_OUT;
      end

      // Take the queue head onto the CPU.
      jrqs_pkg::S_HEAD_RD: begin
        rd_addr   = '0;
        state_nxt = jrqs_pkg::S_HEAD_GET;
      end
      jrqs_pkg::S_HEAD_GET: begin
        cur_nxt   = head_job;
        slice_nxt = quantum_r;
        if (ctx_r == jrqs_pkg::CTX_PREEMPT) begin
          // The preempted job takes the head slot directly.
          we        = 1'b1;
          wa        = '0;
          wd        = nw_r;
          state_nxt = jrqs_pkg::S_OUT;
        end else begin
          count_nxt = count_r - CW'(1);
          idx_nxt   = CW'(1);
          if (count_r > CW'(1)) state_nxt = jrqs_pkg::S_SHDN_RD;
          else begin
            pos_nxt = count_r - CW'(1);
            priority case (ctx_r)
              jrqs_pkg::CTX_PRE_TICK: state_nxt = jrqs_pkg::S_TICK;
              jrqs_pkg::CTX_RR_SWAP:  state_nxt = jrqs_pkg::S_INS_WR;
              default:                state_nxt = jrqs_pkg::S_OUT;
            endcase
          end
        end
      end

      // Close the gap at the head, moving slots down.
      jrqs_pkg::S_SHDN_RD: begin
        rd_addr   = idx_r;
        state_nxt = jrqs_pkg::S_SHDN_WR;
      end
      jrqs_pkg::S_SHDN_WR: begin
        we      = 1'b1;
        wa      = idx_r - CW'(1);
        wd      = rd_data_r;
        idx_nxt = idx_r + CW'(1);
        if (idx_r == count_r) begin
          pos_nxt = count_r;
          priority case (ctx_r)
            jrqs_pkg::CTX_PRE_TICK: state_nxt = jrqs_pkg::S_TICK;
            jrqs_pkg::CTX_RR_SWAP:  state_nxt = jrqs_pkg::S_INS_WR;
            default:                state_nxt = jrqs_pkg::S_OUT;
          endcase
        end else begin
          state_nxt = jrqs_pkg::S_SHDN_RD;
        end
      end

      // Run the current job for one tick, or pass an idle tick.
      jrqs_pkg::S_TICK: begin
        state_nxt = jrqs_pkg::S_OUT;
        if (cur_r.job != 8'd0) begin
          res_nxt.all_done = 1'b0;
          clk_ticks_nxt    = tk_clk;
          cur_nxt.remaining = tk_rem;
          slice_nxt        = tk_slice;
          if (tk_rem == 16'd0) begin
            res_nxt.finished_valid   = 1'b1;
            res_nxt.finished_job     = cur_r.job;
            res_nxt.turnaround_ticks = tk_turn;
            res_nxt.waiting_ticks    = jrqs_pkg::diff_sat(tk_turn, cur_r.burst);
            res_nxt.response_ticks   = jrqs_pkg::diff_sat(cur_r.started, cur_r.arrival);
            cur_nxt.job = 8'd0;
            if (count_r != '0) begin
              ctx_nxt   = jrqs_pkg::CTX_AFTER_DONE;
              state_nxt = jrqs_pkg::S_HEAD_RD;
            end
          end else if (mode_r != jrqs_pkg::MODE_RR && preempt_r && count_r != '0) begin
            nw_nxt           = cur_r;
            nw_nxt.remaining = tk_rem;
            state_nxt        = jrqs_pkg::S_PRE_RD;
          end else if (mode_r == jrqs_pkg::MODE_RR && tk_expired) begin
            if (count_r == '0) slice_nxt = quantum_r;
            else begin
              nw_nxt           = cur_r;
              nw_nxt.remaining = tk_rem;
              ctx_nxt          = jrqs_pkg::CTX_RR_SWAP;
              state_nxt        = jrqs_pkg::S_HEAD_RD;
            end
          end
        end else begin
          res_nxt.cpu_idle = 1'b1;
          if (!res_r.all_done) begin
            if (idle_r < jrqs_pkg::TIME_MAX) idle_nxt = idle_r + 16'd1;
            clk_ticks_nxt = tk_clk;
          end
        end
      end

      // Compare the queue head against the running job.
      jrqs_pkg::S_PRE_RD: begin
        rd_addr   = '0;
        state_nxt = jrqs_pkg::S_PRE_CMP;
      end
      jrqs_pkg::S_PRE_CMP: begin
        if (jrqs_pkg::key_of(mode_r, rd_data_r) < jrqs_pkg::key_of(mode_r, cur_r)) begin
          ctx_nxt   = jrqs_pkg::CTX_PREEMPT;
          state_nxt = jrqs_pkg::S_HEAD_GET;
        end else begin
          state_nxt = jrqs_pkg::S_OUT;
        end
      end

      // Load the result once the output register is free.
      jrqs_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt             = res_r;
          out_nxt.running_job = cur_r.job;
          out_nxt.time_now    = clk_ticks_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = jrqs_pkg::S_IDLE;
        end
      end

      default: state_nxt = jrqs_pkg::S_IDLE;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_r.accepted;
  assign out_queue_position   = out_r.queue_position;
  assign out_running_job      = out_r.running_job;
  assign out_cpu_idle         = out_r.cpu_idle;
  assign out_time_now         = out_r.time_now;
  assign out_finished_valid   = out_r.finished_valid;
  assign out_finished_job     = out_r.finished_job;
  assign out_waiting_ticks    = out_r.waiting_ticks;
  assign out_turnaround_ticks = out_r.turnaround_ticks;
  assign out_response_ticks   = out_r.response_ticks;
  assign out_all_done         = out_r.all_done;

endmodule
